>>> hw/rtl/tmh_pkg.sv
// Package with shared constants and types of the timer deadline heap.
package tmh_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int XW    = AW + 2;

  localparam logic [1:0] KIND_ADDED    = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_EXPIRED  = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic [31:0] dl;
    logic [7:0]  id;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_UP,
    ST_ADD_CMP,
    ST_ADD_DONE,
    ST_TK_CHECK,
    ST_TK_EVAL,
    ST_TK_LAST,
    ST_TK_DREAD,
    ST_TK_DCMP
  } state_t;

endpackage

>>> hw/rtl/tmh_if.sv
// Channel interfaces for the input words and the result words.
interface tmh_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] now_time;
  logic [31:0] delay;
  logic [7:0]  timer_id;
  modport source (output valid, func, now_time, delay, timer_id, input ready);
  modport sink   (input valid, func, now_time, delay, timer_id, output ready);
endinterface

interface tmh_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  expired_id;
  logic [31:0] deadline;
  logic        last;
  modport source (output valid, kind, expired_id, deadline, last, input ready);
  modport sink   (input valid, kind, expired_id, deadline, last, output ready);
endinterface

>>> hw/rtl/timer_deadline_min_heap.sv
// Top level of the timer deadline queue built on a binary min-heap in block RAM.
//
// The block holds up to DEPTH timers in a min-heap kept in one RAM with two registered
// read ports and one write port. It takes one input word at a time and only while idle.
// An add moves the new entry up one level per pass of the read-compare-write loop of the
// sift-up, and writes it where it comes to rest. A tick first looks at the root and, per
// expired timer, moves the last entry down from the root in a sift-down, which reads both
// children at once and compares them in the next cycle. Each result word is held in an
// output register; the block stalls when that register is full and not being taken. The
// RAM needs no clearing: only entries below the fill count are ever used.
module timer_deadline_min_heap
  import tmh_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  tmh_in_if.sink        in_ch,
  tmh_out_if.source     out_ch
);

  // Heap storage and its registered read ports.
  entry_t mem [DEPTH];
  entry_t rda_r, rdb_r;
  logic [AW-1:0] ra, rb, wa;
  entry_t wd;
  logic we;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_r <= mem[ra];
    rdb_r <= mem[rb];
  end

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] pos_r, pos_nxt;        // hole position during a sift
  entry_t        elem_r, elem_nxt;      // the entry that moves through the heap
  logic [31:0]   now_r, now_nxt;
  logic [1:0]    kind_r, kind_nxt;
  entry_t        pend_r, pend_nxt;      // popped timer waiting for its last flag
  logic          pending_r, pending_nxt;

  logic          ov_r, ov_nxt;
  logic [1:0]    okind_r, okind_nxt;
  logic [7:0]    oid_r, oid_nxt;
  logic [31:0]   odl_r, odl_nxt;
  logic          olast_r, olast_nxt;

  logic          out_free;
  logic [32:0]   sum;
  logic [31:0]   add_dl;
  logic [AW-1:0] parent;
  logic [XW-1:0] left_x, right_x;
  logic          left_ok, right_ok, due;

  assign out_free = !ov_r || out_ch.ready;
  assign sum      = {1'b0, in_ch.now_time} + {1'b0, in_ch.delay};
  assign add_dl   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign parent   = (pos_r - AW'(1)) >> 1;
  assign left_x   = {1'b0, pos_r, 1'b1};
  assign right_x  = left_x + XW'(1);
  assign left_ok  = left_x  < XW'(count_r);
  assign right_ok = right_x < XW'(count_r);
  assign due      = (count_r != '0) && !(rda_r.dl > now_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      pending_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      pending_r <= pending_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    elem_r  <= elem_nxt;
    now_r   <= now_nxt;
    kind_r  <= kind_nxt;
    pend_r  <= pend_nxt;
    okind_r <= okind_nxt;
    oid_r   <= oid_nxt;
    odl_r   <= odl_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    entry_t best;
    logic [AW-1:0] best_pos;
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    elem_nxt    = elem_r;
    now_nxt     = now_r;
    kind_nxt    = kind_r;
    pend_nxt    = pend_r;
    pending_nxt = pending_r;
    ov_nxt      = ov_r && !out_ch.ready;
    okind_nxt   = okind_r;
    oid_nxt     = oid_r;
    odl_nxt     = odl_r;
    olast_nxt   = olast_r;
    ra          = '0;
    rb          = '0;
    wa          = pos_r;
    wd          = elem_r;
    we          = 1'b0;
    best        = elem_r;
    best_pos    = pos_r;
    in_ch.ready = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          now_nxt     = in_ch.now_time;
          elem_nxt    = '{dl: add_dl, id: in_ch.timer_id};
          pending_nxt = 1'b0;
          if (in_ch.func == FUNC_TICK) begin
            state_nxt = ST_TK_CHECK;
          end else if (count_r == CW'(DEPTH)) begin
            kind_nxt  = KIND_REJECTED;
            state_nxt = ST_ADD_DONE;
          end else begin
            kind_nxt  = KIND_ADDED;
            pos_nxt   = count_r[AW-1:0];
            count_nxt = count_r + CW'(1);
            state_nxt = ST_ADD_UP;
          end
        end
      end
      ST_ADD_UP: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = ST_ADD_DONE;
        end else begin
          ra        = parent;
          state_nxt = ST_ADD_CMP;
        end
      end
      ST_ADD_CMP: begin
        we = 1'b1;
        if (elem_r.dl < rda_r.dl) begin
          // The parent moves down into the hole and the hole moves up.
          wd        = rda_r;
          pos_nxt   = parent;
          state_nxt = ST_ADD_UP;
        end else begin
          state_nxt = ST_ADD_DONE;
        end
      end
      ST_ADD_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = kind_r;
          oid_nxt   = '0;
          odl_nxt   = elem_r.dl;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_TK_CHECK: begin
        state_nxt = ST_TK_EVAL;
      end
      ST_TK_EVAL: begin
        // A popped timer is only emitted once it is known whether another one follows.
        if ((pending_r || !due) && !out_free) begin
          state_nxt = ST_TK_EVAL;
        end else begin
          if (pending_r) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_EXPIRED;
            oid_nxt   = pend_r.id;
            odl_nxt   = pend_r.dl;
            olast_nxt = !due;
          end else if (!due) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_NONE;
            oid_nxt   = '0;
            odl_nxt   = '0;
            olast_nxt = 1'b1;
          end
          if (due) begin
            pend_nxt    = rda_r;
            pending_nxt = 1'b1;
            count_nxt   = count_r - CW'(1);
            ra          = AW'(count_r - CW'(1));
            state_nxt   = ST_TK_LAST;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TK_LAST: begin
        if (count_r == '0) begin
          state_nxt = ST_TK_CHECK;
        end else begin
          elem_nxt  = rda_r;
          pos_nxt   = '0;
          state_nxt = ST_TK_DREAD;
        end
      end
      ST_TK_DREAD: begin
        ra        = left_x[AW-1:0];
        rb        = right_x[AW-1:0];
        state_nxt = ST_TK_DCMP;
      end
      ST_TK_DCMP: begin
        if (left_ok && (rda_r.dl < best.dl)) begin
          best     = rda_r;
          best_pos = left_x[AW-1:0];
        end
        if (right_ok && (rdb_r.dl < best.dl)) begin
          best     = rdb_r;
          best_pos = right_x[AW-1:0];
        end
        we = 1'b1;
        if (best_pos == pos_r) begin
          state_nxt = ST_TK_CHECK;
        end else begin
          // The smaller child moves up into the hole.
          wd        = best;
          pos_nxt   = best_pos;
          state_nxt = ST_TK_DREAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.kind       = okind_r;
  assign out_ch.expired_id = oid_r;
  assign out_ch.deadline   = odl_r;
  assign out_ch.last       = olast_r;

endmodule

>>> hw/rtl/tmh_checker.sv
// Port checker for the timer deadline heap and its bind statement.
module tmh_checker
  import tmh_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_expired_id,
  input logic [31:0] out_deadline,
  input logic        out_last
);

  // A stalled result word keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_expired_id) && $stable(out_deadline) && $stable(out_last))
    else $error("stalled result word changed");

  // The block works on one word at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // Adds, and ticks with no expired timer, always end with their single result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ADDED || out_kind == KIND_REJECTED ||
      out_kind == KIND_NONE) |-> out_last)
    else $error("single result without last flag");

endmodule

bind timer_deadline_min_heap tmh_checker u_tmh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_expired_id (out_ch.expired_id),
  .out_deadline   (out_ch.deadline),
  .out_last       (out_ch.last)
);
